// ----- rtl/core/spwm_pkg.sv -----
// Shared types, register codes and constants for the SPWM compare value generator.
// Also holds the constant sine series used to build the quarter-wave table.
// Depends on nothing; every other file in rtl/core imports it.
package spwm_pkg;

  // Field widths fixed by the register map and the item format.
  localparam int TCLK_W   = 32;
  localparam int FREQ_W   = 16;
  localparam int RATIO_W  = 11;
  localparam int MOD_W    = 16;
  localparam int IDX_W    = 10;
  localparam int QUO_W    = 16;
  localparam int DIVP_W   = FREQ_W + RATIO_W;
  localparam int MAG_W    = 15;
  localparam int CFG_IDX_W = 3;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMER_CLOCK = 3'd0,
    CFG_SINE_FREQ   = 3'd1,
    CFG_CARRIER     = 3'd2,
    CFG_MOD_INDEX   = 3'd3,
    CFG_THREE_PHASE = 3'd4
  } cfg_reg_t;

  // Register reset values.
  localparam logic [TCLK_W-1:0]  TCLK_RST  = 32'd90000000;
  localparam logic [FREQ_W-1:0]  FREQ_RST  = 16'd50;
  localparam logic [RATIO_W-1:0] RATIO_RST = 11'd500;
  localparam logic [MOD_W-1:0]   MOD_RST   = 16'd26214;

  // Phase offset of two thirds of a turn in a 16-bit phase word.
  localparam logic [QUO_W-1:0] TWO_THIRDS_TURN = 16'd43691;
  // pi/2 in Q30.
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  // 1.0 in the Q30 sum of the compare formula.
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  // Item as it enters the divider.
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } spwm_front_t;

  // Item as it leaves the divider.
  typedef struct packed {
    logic             vld;
    logic             oob;
    logic [QUO_W-1:0] period;
    logic [QUO_W-1:0] phase;
  } spwm_div_t;

  // Q15 sine of x (Q30 radians, 0 to pi/2) by a six-term Taylor series.
  function automatic logic [MAG_W-1:0] sine_from_x(input longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    longint unsigned q;
    longint          sum;
    x2  = (x * x) >> 30;
    t   = x;
    sum = $signed(x);
    t   = ((t * x2) >> 30) / 64'd6;
    sum = sum - $signed(t);
    t   = ((t * x2) >> 30) / 64'd20;
    sum = sum + $signed(t);
    t   = ((t * x2) >> 30) / 64'd42;
    sum = sum - $signed(t);
    t   = ((t * x2) >> 30) / 64'd72;
    sum = sum + $signed(t);
    t   = ((t * x2) >> 30) / 64'd110;
    sum = sum - $signed(t);
    if (sum < 0) begin
      sum = 0;
    end
    q = ($unsigned(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[MAG_W-1:0];
  endfunction

endpackage

// ----- rtl/core/spwm_div.sv -----
// Pipelined restoring divider: one quotient bit per stage for the timer period
// and, in lockstep, for the phase fraction. Imports spwm_pkg.
module spwm_div
  import spwm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  spwm_front_t         in_item,
  input  logic [DIVP_W-1:0]   per_divisor,
  input  logic [RATIO_W-1:0]  ratio,
  input  logic [TCLK_W-1:0]   clk_hz,
  output spwm_div_t           out_item
);

  localparam int STEPS = QUO_W;

  logic               vld_r  [STEPS];
  logic               oob_r  [STEPS];
  logic               sat_r  [STEPS];
  logic [DIVP_W-1:0]  remp_r [STEPS];
  logic [RATIO_W-1:0] remh_r [STEPS];
  logic [QUO_W-1:0]   qp_r   [STEPS];
  logic [QUO_W-1:0]   qh_r   [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic               v_in;
    logic               o_in;
    logic               s_in;
    logic [DIVP_W-1:0]  rp_in;
    logic [RATIO_W-1:0] rh_in;
    logic [QUO_W-1:0]   qp_in;
    logic [QUO_W-1:0]   qh_in;
    logic               bit_in;
    logic [DIVP_W:0]    tp_nxt;
    logic [RATIO_W:0]   th_nxt;

    if (k == 0) begin : g_first
      // The upper half of the dividend seeds the period remainder. If it is
      // not below the divisor, the quotient exceeds 16 bits and saturates.
      // The phase dividend is index times 65536, so the index seeds it.
      assign v_in  = in_item.vld;
      assign o_in  = ({1'b0, in_item.idx} >= ratio);
      assign s_in  = (DIVP_W'(clk_hz[TCLK_W-1:QUO_W]) >= per_divisor);
      assign rp_in = DIVP_W'(clk_hz[TCLK_W-1:QUO_W]);
      assign rh_in = RATIO_W'(in_item.idx);
      assign qp_in = '0;
      assign qh_in = '0;
    end else begin : g_next
      assign v_in  = vld_r[k-1];
      assign o_in  = oob_r[k-1];
      assign s_in  = sat_r[k-1];
      assign rp_in = remp_r[k-1];
      assign rh_in = remh_r[k-1];
      assign qp_in = qp_r[k-1];
      assign qh_in = qh_r[k-1];
    end

    // Trial subtraction; the top bit is set when the divisor does not fit.
    assign bit_in = clk_hz[QUO_W-1-k];
    assign tp_nxt = {rp_in, bit_in} - {1'b0, per_divisor};
    assign th_nxt = {rh_in, 1'b0} - {1'b0, ratio};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      oob_r[k]  <= o_in;
      sat_r[k]  <= s_in;
      qp_r[k]   <= {qp_in[QUO_W-2:0], ~tp_nxt[DIVP_W]};
      qh_r[k]   <= {qh_in[QUO_W-2:0], ~th_nxt[RATIO_W]};
      remp_r[k] <= tp_nxt[DIVP_W] ? {rp_in[DIVP_W-2:0], bit_in} : tp_nxt[DIVP_W-1:0];
      remh_r[k] <= th_nxt[RATIO_W] ? {rh_in[RATIO_W-2:0], 1'b0} : th_nxt[RATIO_W-1:0];
    end
  end

  // Last stage: saturate the period at its full 16-bit range.
  assign out_item.vld    = vld_r[STEPS-1];
  assign out_item.oob    = oob_r[STEPS-1];
  assign out_item.period = sat_r[STEPS-1] ? {QUO_W{1'b1}} : qp_r[STEPS-1];
  assign out_item.phase  = qh_r[STEPS-1];

endmodule

// ----- rtl/core/spwm_compare_value_generator.sv -----
// Top level of the SPWM compare value generator: configuration registers,
// input stage, sine lookup and compare arithmetic. Uses spwm_pkg and spwm_div.
//
// The block takes one sample index in every clock cycle and never asserts
// busy. Each item gives exactly one result, shown on the out_ ports for one
// cycle with out_valid high; the receiver cannot stall, so results must be
// taken as they come. An item's path holds one input stage, one stage for
// the divisor product, the 16-stage bit-per-stage divider that forms the
// timer period and the phase, and four stages for sine lookup and the two
// multiplications. The sine table is a constant ROM of SINE_TABLE_DEPTH+1
// entries built at elaboration; no clearing or fill pass runs after reset.
// Registers may only be written while no item is in flight.
module spwm_compare_value_generator
  import spwm_pkg::*;
#(
  parameter int MAX_RATIO        = 1024,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [IDX_W-1:0]     in_sample_index,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TCLK_W-1:0]    cfg_wdata,
  output logic                 out_valid,
  output logic [QUO_W-1:0]     out_timer_period,
  output logic [QUO_W-1:0]     out_compare_u,
  output logic [QUO_W-1:0]     out_compare_v,
  output logic [QUO_W-1:0]     out_compare_w,
  output logic                 out_index_out_of_range
);

  localparam int TIW   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW    = 16 + TIW;
  localparam int LANES = 3;

  typedef struct packed {
    logic             vld;
    logic             oob;
    logic [QUO_W-1:0] period;
  } spwm_meta_t;

  // Configuration registers.
  logic [TCLK_W-1:0]  tclk_r;
  logic [FREQ_W-1:0]  freq_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [MOD_W-1:0]   mod_r;
  logic               three_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tclk_r  <= TCLK_RST;
      freq_r  <= FREQ_RST;
      ratio_r <= RATIO_RST;
      mod_r   <= MOD_RST;
      three_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TIMER_CLOCK: tclk_r  <= cfg_wdata;
        CFG_SINE_FREQ:   freq_r  <= cfg_wdata[FREQ_W-1:0];
        CFG_CARRIER:     ratio_r <= cfg_wdata[RATIO_W-1:0];
        CFG_MOD_INDEX:   mod_r   <= cfg_wdata[MOD_W-1:0];
        CFG_THREE_PHASE: three_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective frequency and ratio: zero reads as one, ratio clamps at the maximum.
  logic [FREQ_W-1:0]  freq_eff;
  logic [RATIO_W-1:0] ratio_eff;
  logic [DIVP_W-1:0]  divp_r;

  always_comb begin
    freq_eff  = (freq_r == '0) ? FREQ_W'(1) : freq_r;
    ratio_eff = (ratio_r == '0) ? RATIO_W'(1) : ratio_r;
    if (32'(ratio_eff) > MAX_RATIO) begin
      ratio_eff = RATIO_W'(MAX_RATIO);
    end
  end

  // The period divisor is registered and follows the registers in the next
  // cycle; the item spends that cycle in the second input stage.
  always_ff @(posedge clk) begin
    divp_r <= DIVP_W'(freq_eff) * DIVP_W'(ratio_eff);
  end

  // Input stage, then one delay stage so the divisor has settled.
  spwm_front_t in_r;
  spwm_front_t fa_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_r.vld <= 1'b0;
      fa_r.vld <= 1'b0;
    end else begin
      in_r.vld <= start;
      fa_r.vld <= in_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    in_r.idx <= in_sample_index;
    fa_r.idx <= in_r.idx;
  end

  // Timer period and U phase fraction.
  spwm_div_t div_out;

  spwm_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (fa_r),
    .per_divisor (divp_r),
    .ratio       (ratio_eff),
    .clk_hz      (tclk_r),
    .out_item    (div_out)
  );

  // Quarter-wave sine ROM.
  logic [MAG_W-1:0] sine_rom [SINE_TABLE_DEPTH+1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam longint unsigned XK = (64'(k) * PI_HALF_Q30) / SINE_TABLE_DEPTH;
    assign sine_rom[k] = sine_from_x(XK);
  end

  // Stage C: phase of each lane, quadrant fold and table index.
  logic [QUO_W-1:0] ph      [LANES];
  logic [14:0]      fold    [LANES];
  logic [PW-1:0]    tprod   [LANES];
  logic [TIW-1:0]   tidx_r  [LANES];
  logic             c_neg_r [LANES];
  spwm_meta_t       c_r;

  always_comb begin
    ph[0] = div_out.phase;
    ph[1] = div_out.phase + TWO_THIRDS_TURN;
    ph[2] = div_out.phase - TWO_THIRDS_TURN;
    for (int l = 0; l < LANES; l++) begin
      fold[l]  = ph[l][14] ? (15'h4000 - {1'b0, ph[l][13:0]}) : {1'b0, ph[l][13:0]};
      tprod[l] = PW'(fold[l]) * PW'(SINE_TABLE_DEPTH) + PW'(8192);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      tidx_r[l]  <= TIW'(tprod[l] >> 14);
      c_neg_r[l] <= ph[l][15];
    end
    c_r.oob    <= div_out.oob;
    c_r.period <= div_out.period;
  end

  // Stage D: registered table read.
  logic [MAG_W-1:0] mag_r   [LANES];
  logic             d_neg_r [LANES];
  spwm_meta_t       d_r;

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      mag_r[l]   <= sine_rom[tidx_r[l]];
      d_neg_r[l] <= c_neg_r[l];
    end
    d_r.oob    <= c_r.oob;
    d_r.period <= c_r.period;
  end

  // Stage E: 1 + m*sin in Q30, clamped at zero.
  logic [30:0] mprod   [LANES];
  logic [31:0] val_nxt [LANES];
  logic [31:0] val_r   [LANES];
  spwm_meta_t  e_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mprod[l] = 31'(mod_r) * 31'(mag_r[l]);
      if (!d_neg_r[l]) begin
        val_nxt[l] = ONE_Q30 + 32'(mprod[l]);
      end else if (32'(mprod[l]) > ONE_Q30) begin
        val_nxt[l] = '0;
      end else begin
        val_nxt[l] = ONE_Q30 - 32'(mprod[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      val_r[l] <= val_nxt[l];
    end
    e_r.oob    <= d_r.oob;
    e_r.period <= d_r.period;
  end

  // Stage F: scale by the period, clamp to the period, apply the masks.
  logic [47:0]      cprod [LANES];
  logic [QUO_W:0]   cmp   [LANES];
  logic [QUO_W-1:0] cmp_nxt [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      cprod[l] = 48'(val_r[l]) * 48'(e_r.period);
      cmp[l]   = cprod[l][47:31];
      if (cmp[l] > {1'b0, e_r.period}) begin
        cmp_nxt[l] = e_r.period;
      end else begin
        cmp_nxt[l] = cmp[l][QUO_W-1:0];
      end
      if (e_r.oob || (l != 0 && !three_r)) begin
        cmp_nxt[l] = '0;
      end
    end
  end

  // Valid bits of the back stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.vld   <= 1'b0;
      d_r.vld   <= 1'b0;
      e_r.vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      c_r.vld   <= div_out.vld;
      d_r.vld   <= c_r.vld;
      e_r.vld   <= d_r.vld;
      out_valid <= e_r.vld;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    out_timer_period       <= e_r.period;
    out_compare_u          <= cmp_nxt[0];
    out_compare_v          <= cmp_nxt[1];
    out_compare_w          <= cmp_nxt[2];
    out_index_out_of_range <= e_r.oob;
  end

endmodule

// ----- dv/spwm_compare_value_generator_test.sv -----
// Self-checking testbench for the SPWM compare value generator: directed and random sample
// indexes under many register settings, each result checked against a built-in predictor.
// Depends on spwm_pkg and the RTL top level spwm_compare_value_generator.
module spwm_compare_value_generator_test
  import spwm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RATIO_LIMIT  = 1024;
  localparam int TABLE_DEPTH  = 256;
  localparam int LATENCY      = 21;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1100;

  // One table point as it leaves the block.
  typedef struct {
    logic [QUO_W-1:0] period;
    logic [QUO_W-1:0] u;
    logic [QUO_W-1:0] v;
    logic [QUO_W-1:0] w;
    logic             oob;
  } pwm_point_t;

  // Predicts table points from the register copy and checks the block's results in order.
  class spwm_point_checker;
    logic [TCLK_W-1:0]  timer_clock;
    logic [FREQ_W-1:0]  sine_freq;
    logic [RATIO_W-1:0] carrier;
    logic [MOD_W-1:0]   mod_index;
    logic               three_phase;
    int                 quarter_wave[TABLE_DEPTH+1];
    pwm_point_t         expected_points[$];
    int unsigned        mismatches;

    // Build the quarter-wave Q15 sine by an integer Taylor series in Q30.
    function new();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      longint          q;
      for (int k = 0; k <= TABLE_DEPTH; k++) begin
        x    = (longint'(k) * PI_HALF_Q30) / TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 5; n++) begin
          term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) begin
            acc = acc - longint'(term);
          end else begin
            acc = acc + longint'(term);
          end
        end
        if (acc < 0) begin
          acc = 0;
        end
        q = (acc * 32768 + (64'sd1 <<< 29)) >>> 30;
        if (q > 32767) begin
          q = 32767;
        end
        quarter_wave[k] = int'(q);
      end
      timer_clock = TCLK_RST;
      sine_freq   = FREQ_RST;
      carrier     = RATIO_RST;
      mod_index   = MOD_RST;
      three_phase = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [TCLK_W-1:0] d);
      case (r)
        CFG_TIMER_CLOCK: timer_clock = d;
        CFG_SINE_FREQ:   sine_freq   = d[FREQ_W-1:0];
        CFG_CARRIER:     carrier     = d[RATIO_W-1:0];
        CFG_MOD_INDEX:   mod_index   = d[MOD_W-1:0];
        CFG_THREE_PHASE: three_phase = d[0];
        default: ;
      endcase
    endfunction

    // A zero ratio counts as one and large ratios are clamped.
    function int eff_ratio();
      int r;
      r = (carrier == '0) ? 1 : int'(carrier);
      if (r > RATIO_LIMIT) begin
        r = RATIO_LIMIT;
      end
      return r;
    endfunction

    function logic [QUO_W-1:0] timer_period();
      longint unsigned f;
      longint unsigned per;
      f   = (sine_freq == '0) ? 1 : longint'(sine_freq);
      per = (longint'(timer_clock) / f) / longint'(eff_ratio());
      if (per > 65535) begin
        per = 65535;
      end
      return per[QUO_W-1:0];
    endfunction

    // Quarter-wave lookup: mirror the offset in odd quadrants, negate in the lower half.
    function int sine_at(logic [QUO_W-1:0] phase);
      int f;
      int entry;
      int s;
      f = int'(phase[13:0]);
      if (phase[14]) begin
        f = 16384 - f;
      end
      entry = (f * TABLE_DEPTH + 8192) >>> 14;
      if (entry > TABLE_DEPTH) begin
        entry = TABLE_DEPTH;
      end
      s = quarter_wave[entry];
      return phase[15] ? -s : s;
    endfunction

    // floor((2^30 + m*s) * period / 2^31), kept within 0 and the period.
    function logic [QUO_W-1:0] compare_at(logic [QUO_W-1:0] phase, logic [QUO_W-1:0] period);
      longint          level;
      longint unsigned c;
      level = (64'sd1 <<< 30) + longint'(mod_index) * longint'(sine_at(phase));
      if (level < 0) begin
        level = 0;
      end
      c = (longint'(level) * longint'(period)) >> 31;
      if (c > longint'(period)) begin
        c = longint'(period);
      end
      return c[QUO_W-1:0];
    endfunction

    function void note_index(logic [IDX_W-1:0] idx);
      pwm_point_t       p;
      int               r;
      logic [QUO_W-1:0] pu;
      r        = eff_ratio();
      p.period = timer_period();
      p.u      = '0;
      p.v      = '0;
      p.w      = '0;
      p.oob    = 1'b0;
      if (int'(idx) >= r) begin
        p.oob = 1'b1;
      end else begin
        pu  = QUO_W'((longint'(idx) << 16) / r);
        p.u = compare_at(pu, p.period);
        if (three_phase) begin
          p.v = compare_at(QUO_W'(pu + TWO_THIRDS_TURN), p.period);
          p.w = compare_at(QUO_W'(pu - TWO_THIRDS_TURN), p.period);
        end
      end
      expected_points.push_back(p);
    endfunction

    function void check_field(string name, logic [QUO_W-1:0] exp_val, logic [QUO_W-1:0] act);
      if (exp_val !== act) begin
        $error("%s: expected %0d, actual %0d", name, exp_val, act);
        mismatches++;
      end
    endfunction

    function void check_result(logic [QUO_W-1:0] period, logic [QUO_W-1:0] u,
                               logic [QUO_W-1:0] v, logic [QUO_W-1:0] w, logic oob);
      pwm_point_t p;
      if (expected_points.size() == 0) begin
        $error("result arrived with no item outstanding");
        mismatches++;
        return;
      end
      p = expected_points.pop_front();
      check_field("timer_period", p.period, period);
      check_field("compare_u", p.u, u);
      check_field("compare_v", p.v, v);
      check_field("compare_w", p.w, w);
      check_field("index_out_of_range", QUO_W'(p.oob), QUO_W'(oob));
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [IDX_W-1:0]     in_sample_index;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TCLK_W-1:0]    cfg_wdata;
  logic                 out_valid;
  logic [QUO_W-1:0]     out_timer_period;
  logic [QUO_W-1:0]     out_compare_u;
  logic [QUO_W-1:0]     out_compare_v;
  logic [QUO_W-1:0]     out_compare_w;
  logic                 out_index_out_of_range;
  int unsigned          cycles = 0;

  spwm_point_checker point_check = new();

  spwm_compare_value_generator i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_sample_index        (in_sample_index),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .out_valid              (out_valid),
    .out_timer_period       (out_timer_period),
    .out_compare_u          (out_compare_u),
    .out_compare_v          (out_compare_v),
    .out_compare_w          (out_compare_w),
    .out_index_out_of_range (out_index_out_of_range)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Observe every edge: register writes, accepted items and results, plus the run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (rst_n) begin
      if (cfg_we) begin
        point_check.set_reg(cfg_reg_t'(cfg_index), cfg_wdata);
      end
      if (start && !busy) begin
        point_check.note_index(in_sample_index);
      end
      if (out_valid) begin
        point_check.check_result(out_timer_period, out_compare_u, out_compare_v,
                                 out_compare_w, out_index_out_of_range);
      end
    end
  end

  // Offer one item after an optional gap and hold it until the block takes it.
  task automatic send_index(logic [IDX_W-1:0] idx, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_sample_index <= idx;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_list(int idxs[$]);
    foreach (idxs[i]) begin
      send_index(IDX_W'(idxs[i]), $urandom_range(0, 11));
    end
  endtask

  // Stop sending and wait until every outstanding item has produced its result.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (point_check.pending() != 0) @(posedge clk);
  endtask

  task automatic put_reg(cfg_reg_t r, logic [TCLK_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= d;
    @(posedge clk);
  endtask

  // Write all five registers back to back; the extra edge lets the checker catch up.
  task automatic write_config(logic [TCLK_W-1:0] tclk, logic [FREQ_W-1:0] freq,
                              logic [RATIO_W-1:0] ratio, logic [MOD_W-1:0] mod,
                              logic three);
    put_reg(CFG_TIMER_CLOCK, tclk);
    put_reg(CFG_SINE_FREQ, TCLK_W'(freq));
    put_reg(CFG_CARRIER, TCLK_W'(ratio));
    put_reg(CFG_MOD_INDEX, TCLK_W'(mod));
    put_reg(CFG_THREE_PHASE, TCLK_W'(three));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random setting, biased toward the extremes and toward periods that do not saturate.
  task automatic random_config();
    logic [TCLK_W-1:0]  tclk;
    logic [FREQ_W-1:0]  freq;
    logic [RATIO_W-1:0] ratio;
    logic [MOD_W-1:0]   mod;
    case ($urandom_range(0, 3))
      0:       tclk = $urandom();
      1:       tclk = $urandom_range(1000000, 200000000);
      2:       tclk = 32'hFFFF_FFFF;
      default: tclk = $urandom_range(1, 100000);
    endcase
    case ($urandom_range(0, 3))
      0:       freq = FREQ_W'($urandom_range(0, 65535));
      1:       freq = '0;
      default: freq = FREQ_W'($urandom_range(1, 400));
    endcase
    case ($urandom_range(0, 4))
      0:       ratio = RATIO_W'($urandom_range(0, 2047));
      1:       ratio = RATIO_W'($urandom_range(1, 8));
      2:       ratio = 11'd1024;
      default: ratio = RATIO_W'($urandom_range(1, 1024));
    endcase
    case ($urandom_range(0, 4))
      0:       mod = MOD_W'($urandom_range(0, 65535));
      1:       mod = 16'd32768;
      2:       mod = '0;
      default: mod = MOD_W'($urandom_range(0, 32768));
    endcase
    write_config(tclk, freq, ratio, mod, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int               sent;
    int               n;
    int               r;
    bit               no_idle;
    logic [IDX_W-1:0] idx;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_sample_index <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_TIMER_CLOCK;
    cfg_wdata       <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: both ends of the period, and indexes at and past the ratio.
    send_list('{0, 125, 250, 499, 500, 1023});
    drain();
    // Saturated period, full modulation, three phases over the largest ratio.
    write_config(32'hFFFF_FFFF, 16'd1, 11'd1024, 16'd32768, 1'b1);
    send_list('{0, 256, 512, 768, 1023});
    drain();
    // Zero frequency and ratio act as one; modulation above 1.0 clamps the compares.
    write_config(32'd1000, 16'd0, 11'd0, 16'd65535, 1'b1);
    send_list('{0, 1, 1023});
    drain();
    // Ratio above the maximum is clamped; a timer clock this slow gives a zero period.
    write_config(32'd1, 16'd65535, 11'd2047, 16'd0, 1'b0);
    send_list('{1023, 0});
    drain();
    // Tiny ratio in three-phase mode, including the first index out of range.
    write_config(32'd90000000, 16'd50, 11'd3, 16'd32768, 1'b1);
    send_list('{0, 1, 2, 3});
    drain();

    // Random phases: mostly indexes within the ratio, some anywhere in the field.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      random_config();
      r       = point_check.eff_ratio();
      n       = $urandom_range(40, 140);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          idx = IDX_W'($urandom_range(0, 1023));
        end else begin
          idx = IDX_W'($urandom_range(0, r - 1));
        end
        // Midway through each phase, let the pipeline run dry once.
        if (k == n / 2) begin
          drain();
        end
        send_index(idx, no_idle ? 0 : $urandom_range(0, 11));
        sent++;
      end
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (point_check.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
